>>> hdl/vrt_pkg.sv
// ----------------------------------------------------------------------------
// vrt_pkg: shared types and constants for the voxel ray traversal block
// Result kinds, saturation limits and the command word of the iterative unit.
// ----------------------------------------------------------------------------
package vrt_pkg;

    localparam logic [1:0]  KIND_QUERY = 2'd0;
    localparam logic [1:0]  KIND_HIT   = 2'd1;
    localparam logic [1:0]  KIND_MISS  = 2'd2;

    localparam logic [23:0] SAT24      = 24'hFFFFFF;
    localparam logic [16:0] U_MAX      = 17'd65536;

    typedef enum logic
    {
        MODE_SQRT,
        MODE_DIV
    } iter_mode_t;

    // Command to the shared square root / divide unit
    typedef struct packed
    {
        logic        start;
        iter_mode_t  mode;
        logic [63:0] num;       // remaining dividend bits, left aligned
        logic [35:0] rem_init;  // initial partial remainder
        logic [31:0] divisor;
        logic [5:0]  steps;     // result bits to produce
    } iter_cmd_t;

endpackage

>>> hdl/vrt_iter_unit.sv
// ----------------------------------------------------------------------------
// vrt_iter_unit: shared restoring square root / divide unit
// One result bit per cycle; one compare and subtract serves both operations.
// ----------------------------------------------------------------------------
module vrt_iter_unit
(
    input  logic               clk,
    input  logic               rst_n,
    input  vrt_pkg::iter_cmd_t cmd,
    output logic               done,
    output logic [31:0]        quot
);
    import vrt_pkg::*;

    logic        busy_reg;
    logic        done_reg;
    logic [5:0]  cnt_reg;
    iter_mode_t  mode_reg;
    logic [63:0] num_reg;
    logic [35:0] rem_reg;
    logic [31:0] div_reg;
    logic [31:0] q_reg;

    logic [35:0] shifted;
    logic [35:0] trial;
    logic        ge;

    // Bring in the next dividend bits and form the trial subtrahend
    always_comb
    begin
        if (mode_reg == MODE_SQRT)
        begin
            shifted = {rem_reg[33:0], num_reg[63:62]};
            trial   = {2'b00, q_reg, 2'b01};
        end
        else
        begin
            shifted = {rem_reg[34:0], num_reg[63]};
            trial   = {4'b0000, div_reg};
        end
        ge = (shifted >= trial);
    end

    // Load a command, then iterate one bit per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            mode_reg <= MODE_SQRT;
            num_reg  <= '0;
            rem_reg  <= '0;
            div_reg  <= '0;
            q_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cmd.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= cmd.steps;
                mode_reg <= cmd.mode;
                num_reg  <= cmd.num;
                rem_reg  <= cmd.rem_init;
                div_reg  <= cmd.divisor;
                q_reg    <= '0;
            end
            else if (busy_reg)
            begin
                rem_reg <= ge ? (shifted - trial) : shifted;
                q_reg   <= {q_reg[30:0], ge};
                num_reg <= (mode_reg == MODE_SQRT) ? {num_reg[61:0], 2'b00}
                                                   : {num_reg[62:0], 1'b0};
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

>>> hdl/voxel_ray_traversal.sv
// ----------------------------------------------------------------------------
// voxel_ray_traversal: fixed point 3D voxel grid walk
// Sets up a ray and steps it voxel by voxel, asking which voxels are solid.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries input items. s_tuser is the action: 0 starts a ray from the
//   origin and direction in s_tdata, 1 answers the last query with is_solid.
//   m_* carries result items: m_tuser is the kind (query, hit, miss), m_tdata
//   the voxel, the previous voxel and the distance of entry.
//   cfg_* writes the reach distance (unsigned Q8.16); the user is to write it only
//   while the block is idle, which the block itself does not enforce.
// Setup and stepping:
//   An answer is stepped in the accept cycle and its result is valid in the
//   next cycle. A start squares and sums the direction components, then runs
//   the 32-step square root and 18, 24 and 24 division steps per moving axis,
//   all on one shared bit-serial unit. A zero axis skips its divisions; a
//   saturating boundary or delta skips its division. The block is not ready
//   while a start is set up.
// Reset clears the ray (no ray active) and sets reach to 5.0.
// A stalled receiver holds the result in the output register; the block takes
// the next item only in the cycle that result is taken or once it has gone.
// An answer while no ray is active is dropped without a result.
// ----------------------------------------------------------------------------
module voxel_ray_traversal
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [151:0] s_tdata,  // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                                   // is_solid, zero pad
    input  logic         s_tuser,  // action
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [143:0] m_tdata,  // voxel_x, voxel_y, voxel_z, place_x, place_y, place_z,
                                   // hit_distance
    output logic [1:0]   m_tuser,  // kind
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [23:0]  cfg_data
);
    import vrt_pkg::*;

    typedef enum logic [3:0]
    {
        ST_IDLE,
        ST_SUMSQ,
        ST_SQRT,
        ST_AXIS,
        ST_DIVU,
        ST_NB,
        ST_NBW,
        ST_DL,
        ST_DLW,
        ST_EMIT
    } state_t;

    state_t      state_reg;
    logic [23:0] reach_reg;
    logic        active_reg;
    logic        m_valid_reg;
    logic [1:0]  kind_reg;
    logic [1:0]  axis_reg;
    logic [31:0] len2_reg;
    logic [31:0] s_reg;
    logic [16:0] u_reg;
    iter_cmd_t   cmd_reg;

    logic [19:0] cur_reg  [3];
    logic [19:0] prev_reg [3];
    logic        sign_reg [3];
    logic [23:0] nb_reg   [3];
    logic [23:0] dl_reg   [3];
    logic [15:0] mag_reg  [3];
    logic        neg_reg  [3];
    logic [11:0] frac_reg [3];
    logic [23:0] trav_reg;

    logic        iter_done;
    logic [31:0] iter_quot;

    logic        out_free;
    logic        accept;
    logic [31:0] len2_next;
    logic [12:0] f_cur;
    logic [16:0] u_cap;
    logic [1:0]  step_axis;
    logic [24:0] nb_sum;
    logic [23:0] nb_new;
    logic [15:0] dir_in   [3];
    logic [31:0] org_in   [3];

    vrt_iter_unit u_iter
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_reg),
        .done  (iter_done),
        .quot  (iter_quot)
    );

    // Handshakes
    assign out_free  = !m_valid_reg || m_tready;
    assign s_tready  = (state_reg == ST_IDLE) && out_free;
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // Unpack input fields
    assign org_in[0] = s_tdata[31:0];
    assign org_in[1] = s_tdata[63:32];
    assign org_in[2] = s_tdata[95:64];
    assign dir_in[0] = s_tdata[111:96];
    assign dir_in[1] = s_tdata[127:112];
    assign dir_in[2] = s_tdata[143:128];

    // Setup arithmetic for the current axis
    always_comb
    begin
        len2_next = len2_reg + (mag_reg[axis_reg] * mag_reg[axis_reg]);
        f_cur     = neg_reg[axis_reg] ? {1'b0, frac_reg[axis_reg]}
                                      : (13'd4096 - {1'b0, frac_reg[axis_reg]});
        u_cap     = (iter_quot > {15'd0, U_MAX}) ? U_MAX : iter_quot[16:0];
    end

    // Step choice: least boundary, ties go to z, then y
    always_comb
    begin
        if (nb_reg[0] < nb_reg[1])
        begin
            step_axis = (nb_reg[0] < nb_reg[2]) ? 2'd0 : 2'd2;
        end
        else
        begin
            step_axis = (nb_reg[1] < nb_reg[2]) ? 2'd1 : 2'd2;
        end
        nb_sum = {1'b0, nb_reg[step_axis]} + {1'b0, dl_reg[step_axis]};
        nb_new = nb_sum[24] ? SAT24 : nb_sum[23:0];
    end

    // Sequencer, ray state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            reach_reg   <= 24'd327680;
            active_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
            kind_reg    <= KIND_QUERY;
            axis_reg    <= '0;
            len2_reg    <= '0;
            s_reg       <= '0;
            u_reg       <= '0;
            cmd_reg     <= '0;
            trav_reg    <= '0;
            for (int i = 0; i < 3; i++)
            begin
                cur_reg[i]  <= '0;
                prev_reg[i] <= '0;
                sign_reg[i] <= 1'b0;
                nb_reg[i]   <= '0;
                dl_reg[i]   <= '0;
                mag_reg[i]  <= '0;
                neg_reg[i]  <= 1'b0;
                frac_reg[i] <= '0;
            end
        end
        else
        begin
            cmd_reg.start <= 1'b0;
            if (m_valid_reg && m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready)
            begin
                reach_reg <= cfg_data;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept && !s_tuser)
                    begin
                        // Latch the ray and set up the origin voxel
                        for (int i = 0; i < 3; i++)
                        begin
                            cur_reg[i]  <= org_in[i][31:12];
                            prev_reg[i] <= org_in[i][31:12];
                            frac_reg[i] <= org_in[i][11:0];
                            neg_reg[i]  <= dir_in[i][15];
                            mag_reg[i]  <= dir_in[i][15] ? (16'd0 - dir_in[i]) : dir_in[i];
                        end
                        trav_reg   <= '0;
                        len2_reg   <= '0;
                        axis_reg   <= 2'd0;
                        active_reg <= 1'b0;
                        state_reg  <= ST_SUMSQ;
                    end
                    else if (accept && active_reg)
                    begin
                        m_valid_reg <= 1'b1;
                        if (s_tdata[144])
                        begin
                            kind_reg   <= KIND_HIT;
                            active_reg <= 1'b0;
                        end
                        else
                        begin
                            // Advance to the neighbor voxel
                            for (int i = 0; i < 3; i++)
                            begin
                                prev_reg[i] <= cur_reg[i];
                            end
                            cur_reg[step_axis] <= sign_reg[step_axis]
                                ? (cur_reg[step_axis] - 20'd1)
                                : (cur_reg[step_axis] + 20'd1);
                            trav_reg          <= nb_reg[step_axis];
                            nb_reg[step_axis] <= nb_new;
                            if (nb_reg[step_axis] < reach_reg)
                            begin
                                kind_reg <= KIND_QUERY;
                            end
                            else
                            begin
                                kind_reg   <= KIND_MISS;
                                active_reg <= 1'b0;
                            end
                        end
                    end
                end

                ST_SUMSQ:
                begin
                    len2_reg <= len2_next;
                    if (axis_reg == 2'd2)
                    begin
                        cmd_reg.start    <= 1'b1;
                        cmd_reg.mode     <= MODE_SQRT;
                        cmd_reg.num      <= {len2_next, 32'd0};
                        cmd_reg.rem_init <= '0;
                        cmd_reg.divisor  <= '0;
                        cmd_reg.steps    <= 6'd32;
                        state_reg        <= ST_SQRT;
                    end
                    else
                    begin
                        axis_reg <= axis_reg + 2'd1;
                    end
                end

                ST_SQRT:
                begin
                    if (iter_done)
                    begin
                        s_reg     <= iter_quot;
                        axis_reg  <= 2'd0;
                        state_reg <= ST_AXIS;
                    end
                end

                ST_AXIS:
                begin
                    if (mag_reg[axis_reg] == 16'd0 || s_reg == 32'd0)
                    begin
                        // Zero axis never steps within reach
                        sign_reg[axis_reg] <= 1'b0;
                        nb_reg[axis_reg]   <= SAT24;
                        dl_reg[axis_reg]   <= SAT24;
                        state_reg          <= (axis_reg == 2'd2) ? ST_EMIT : ST_AXIS;
                        axis_reg           <= axis_reg + 2'd1;
                    end
                    else
                    begin
                        cmd_reg.start    <= 1'b1;
                        cmd_reg.mode     <= MODE_DIV;
                        cmd_reg.num      <= '0;
                        cmd_reg.rem_init <= {6'd0, mag_reg[axis_reg], 14'd0};
                        cmd_reg.divisor  <= s_reg;
                        cmd_reg.steps    <= 6'd18;
                        state_reg        <= ST_DIVU;
                    end
                end

                ST_DIVU:
                begin
                    if (iter_done)
                    begin
                        u_reg     <= u_cap;
                        state_reg <= ST_NB;
                    end
                end

                ST_NB:
                begin
                    if (u_reg == 17'd0)
                    begin
                        sign_reg[axis_reg] <= 1'b0;
                        nb_reg[axis_reg]   <= SAT24;
                        dl_reg[axis_reg]   <= SAT24;
                        state_reg          <= (axis_reg == 2'd2) ? ST_EMIT : ST_AXIS;
                        axis_reg           <= axis_reg + 2'd1;
                    end
                    else
                    begin
                        sign_reg[axis_reg] <= neg_reg[axis_reg];
                        if ({8'd0, f_cur[12:4]} >= u_reg)
                        begin
                            nb_reg[axis_reg] <= SAT24;
                            state_reg        <= ST_DL;
                        end
                        else
                        begin
                            cmd_reg.start    <= 1'b1;
                            cmd_reg.mode     <= MODE_DIV;
                            cmd_reg.num      <= {f_cur[3:0], 60'd0};
                            cmd_reg.rem_init <= {27'd0, f_cur[12:4]};
                            cmd_reg.divisor  <= {15'd0, u_reg};
                            cmd_reg.steps    <= 6'd24;
                            state_reg        <= ST_NBW;
                        end
                    end
                end

                ST_NBW:
                begin
                    if (iter_done)
                    begin
                        nb_reg[axis_reg] <= iter_quot[23:0];
                        state_reg        <= ST_DL;
                    end
                end

                ST_DL:
                begin
                    if (u_reg <= 17'd256)
                    begin
                        dl_reg[axis_reg] <= SAT24;
                        state_reg        <= (axis_reg == 2'd2) ? ST_EMIT : ST_AXIS;
                        axis_reg         <= axis_reg + 2'd1;
                    end
                    else
                    begin
                        cmd_reg.start    <= 1'b1;
                        cmd_reg.mode     <= MODE_DIV;
                        cmd_reg.num      <= '0;
                        cmd_reg.rem_init <= 36'd256;
                        cmd_reg.divisor  <= {15'd0, u_reg};
                        cmd_reg.steps    <= 6'd24;
                        state_reg        <= ST_DLW;
                    end
                end

                ST_DLW:
                begin
                    if (iter_done)
                    begin
                        dl_reg[axis_reg] <= iter_quot[23:0];
                        state_reg        <= (axis_reg == 2'd2) ? ST_EMIT : ST_AXIS;
                        axis_reg         <= axis_reg + 2'd1;
                    end
                end

                ST_EMIT:
                begin
                    // Report the origin voxel once the output register is free
                    if (out_free)
                    begin
                        m_valid_reg <= 1'b1;
                        if (reach_reg != 24'd0)
                        begin
                            kind_reg   <= KIND_QUERY;
                            active_reg <= 1'b1;
                        end
                        else
                        begin
                            kind_reg   <= KIND_MISS;
                            active_reg <= 1'b0;
                        end
                        state_reg <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Ray state only changes once the held result is taken or gone, so drive it directly
    assign m_tvalid = m_valid_reg;
    assign m_tuser  = kind_reg;
    assign m_tdata  = {trav_reg, prev_reg[2], prev_reg[1], prev_reg[0],
                       cur_reg[2], cur_reg[1], cur_reg[0]};

endmodule
